// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared widths, codes and types of the line segment clipper.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS   = 4;

  localparam int OUT_BITS   = COORD_BITS + OUT_FRAC_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int REM_BITS   = MAG_BITS + 1;
  localparam int U_BITS     = PARAM_FRAC_BITS + 1;
  localparam int PROD_BITS  = U_BITS + 1 + DIFF_BITS;
  localparam int SHIFT_BITS = PARAM_FRAC_BITS - OUT_FRAC_BITS;

  localparam logic [U_BITS-1:0] U_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
  localparam logic [U_BITS-1:0] U_SAT = U_ONE | U_BITS'(1);

  // quotient bits resolved per divider stage
  localparam int STEP_BITS  = 3;
  localparam int DIV_STAGES = (U_BITS + STEP_BITS - 1) / STEP_BITS;

  localparam int NUM_TESTS   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = PTR_BITS + 1;

  localparam int ADDR_BITS    = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOP    = 2'd3;

  typedef struct packed {
    logic                p_pos;
    logic                p_neg;
    logic                q_neg;
    logic                q_pos;
    logic [MAG_BITS-1:0] mag_q;
    logic [MAG_BITS-1:0] mag_p;
  } bound_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [DIFF_BITS-1:0]  dx;
    logic signed [DIFF_BITS-1:0]  dy;
    bound_t [NUM_TESTS-1:0]       bnd;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [U_BITS-1:0]   quo;
    logic                sat;
  } div_t;

endpackage

// ===== rtl/lsc_front.sv =====
// ----------------------------------------------------------------------------
// lsc_front
// Forms the four boundary tests of a segment: signs and magnitudes of p, q.
// ----------------------------------------------------------------------------
module lsc_front (
  input  logic signed [lsc_pkg::COORD_BITS-1:0] window_left,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] window_right,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] window_bottom,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] window_top,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] end_y,
  output lsc_pkg::seg_t                         seg
);
  import lsc_pkg::*;

  logic signed [DIFF_BITS-1:0] p [NUM_TESTS];
  logic signed [DIFF_BITS-1:0] q [NUM_TESTS];
  logic signed [DIFF_BITS-1:0] dx, dy;

  function automatic logic [MAG_BITS-1:0] mag(logic signed [DIFF_BITS-1:0] v);
    logic signed [DIFF_BITS-1:0] n;
    n = -v;
    return v[DIFF_BITS-1] ? MAG_BITS'(n) : MAG_BITS'(v);
  endfunction

  always_comb begin
    dx = DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
    dy = DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
    p[0] = -dx;
    q[0] = DIFF_BITS'(start_x) - DIFF_BITS'(window_left);
    p[1] = dx;
    q[1] = DIFF_BITS'(window_right) - DIFF_BITS'(start_x);
    p[2] = -dy;
    q[2] = DIFF_BITS'(start_y) - DIFF_BITS'(window_bottom);
    p[3] = dy;
    q[3] = DIFF_BITS'(window_top) - DIFF_BITS'(start_y);
    seg.x1 = start_x;
    seg.y1 = start_y;
    seg.dx = dx;
    seg.dy = dy;
    for (int t = 0; t < NUM_TESTS; t++) begin
      seg.bnd[t].p_pos = !p[t][DIFF_BITS-1] && (p[t] != '0);
      seg.bnd[t].p_neg = p[t][DIFF_BITS-1];
      seg.bnd[t].q_neg = q[t][DIFF_BITS-1];
      seg.bnd[t].q_pos = !q[t][DIFF_BITS-1] && (q[t] != '0);
      seg.bnd[t].mag_q = mag(q[t]);
      seg.bnd[t].mag_p = mag(p[t]);
    end
  end

endmodule

// ===== rtl/lsc_queue.sv =====
// ----------------------------------------------------------------------------
// lsc_queue
// Short register queue between the classifying front and the clipping back.
// ----------------------------------------------------------------------------
module lsc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  lsc_pkg::seg_t  wdata,
  input  logic           rd,
  output lsc_pkg::seg_t  rdata,
  output lsc_pkg::qstat_t stat
);
  import lsc_pkg::*;

  seg_t                mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/lsc_back.sv =====
// ----------------------------------------------------------------------------
// lsc_back
// Clipping pipeline: pipelined ratio dividers, boundary test chain,
// interpolation multiply and output register.
// ----------------------------------------------------------------------------
module lsc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  lsc_pkg::seg_t                       seg,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic                                visible,
  output logic signed [lsc_pkg::OUT_BITS-1:0] clip_start_x,
  output logic signed [lsc_pkg::OUT_BITS-1:0] clip_start_y,
  output logic signed [lsc_pkg::OUT_BITS-1:0] clip_end_x,
  output logic signed [lsc_pkg::OUT_BITS-1:0] clip_end_y
);
  import lsc_pkg::*;

  logic adv;
  logic out_valid;

  // divider pipeline
  logic dv   [DIV_STAGES+1];
  seg_t dseg [DIV_STAGES+1];
  div_t ddiv [DIV_STAGES+1][NUM_TESTS];
  div_t dnxt [DIV_STAGES+1][NUM_TESTS];

  // test stage
  logic                         tv, t_vis;
  logic [U_BITS-1:0]            t_u1, t_u2;
  logic signed [COORD_BITS-1:0] t_x1, t_y1;
  logic signed [DIFF_BITS-1:0]  t_dx, t_dy;

  // multiply stage
  logic                         mv, m_vis, m_start, m_end;
  logic signed [PROD_BITS-1:0]  m_sx, m_sy, m_ex, m_ey;
  logic signed [COORD_BITS-1:0] m_x1, m_y1;
  logic signed [DIFF_BITS-1:0]  m_dx, m_dy;

  logic [U_BITS-1:0] r [NUM_TESTS];
  logic              vis_c;
  logic [U_BITS-1:0] u1_c, u2_c;

  logic signed [OUT_BITS-1:0] sx0, sy0, ex0, ey0, sxi, syi, exi, eyi;

  function automatic div_t div_step(div_t d, logic [MAG_BITS-1:0] mq,
                                    logic [MAG_BITS-1:0] mp, int s);
    div_t                o;
    logic [REM_BITS-1:0] r2;
    int                  k;
    o = d;
    for (int j = 0; j < STEP_BITS; j++) begin
      k = PARAM_FRAC_BITS - (s - 1) * STEP_BITS - j;
      if (k >= 0) begin
        r2 = {o.rem[REM_BITS-2:0], (k == PARAM_FRAC_BITS) ? mq[0] : 1'b0};
        if (r2 >= {1'b0, mp}) begin
          r2    = r2 - {1'b0, mp};
          o.quo = o.quo | (U_BITS'(1) << k);
        end
        o.rem = r2;
      end
    end
    return o;
  endfunction

  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid;

  always_comb begin
    for (int t = 0; t < NUM_TESTS; t++) begin
      dnxt[0][t].rem = REM_BITS'(seg.bnd[t].mag_q >> 1);
      dnxt[0][t].quo = '0;
      // quotient needs more than U_BITS bits when |q| >= 2|p|
      dnxt[0][t].sat = ({1'b0, seg.bnd[t].mag_q} >= {seg.bnd[t].mag_p, 1'b0});
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      for (int t = 0; t < NUM_TESTS; t++) begin
        dnxt[s][t] = div_step(ddiv[s-1][t], dseg[s-1].bnd[t].mag_q,
                              dseg[s-1].bnd[t].mag_p, s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dseg[0] <= seg;
      for (int t = 0; t < NUM_TESTS; t++) ddiv[0][t] <= dnxt[0][t];
      for (int s = 1; s <= DIV_STAGES; s++) begin
        dseg[s] <= dseg[s-1];
        for (int t = 0; t < NUM_TESTS; t++) ddiv[s][t] <= dnxt[s][t];
      end
    end
  end

  // boundary tests in order
  always_comb begin
    vis_c = 1'b1;
    u1_c  = '0;
    u2_c  = U_ONE;
    for (int t = 0; t < NUM_TESTS; t++) begin
      r[t] = (ddiv[DIV_STAGES][t].sat || ddiv[DIV_STAGES][t].quo > U_SAT) ?
             U_SAT : ddiv[DIV_STAGES][t].quo;
      if (vis_c) begin
        if (dseg[DIV_STAGES].bnd[t].p_pos) begin
          if (dseg[DIV_STAGES].bnd[t].q_neg || r[t] < u1_c) vis_c = 1'b0;
          else if (r[t] < u2_c) u2_c = r[t];
        end else if (dseg[DIV_STAGES].bnd[t].p_neg) begin
          if (!dseg[DIV_STAGES].bnd[t].q_pos) begin
            if (r[t] > u2_c) vis_c = 1'b0;
            else if (r[t] > u1_c) u1_c = r[t];
          end
        end else if (dseg[DIV_STAGES].bnd[t].q_neg) begin
          vis_c = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_vis <= vis_c;
      t_u1  <= u1_c;
      t_u2  <= u2_c;
      t_x1  <= dseg[DIV_STAGES].x1;
      t_y1  <= dseg[DIV_STAGES].y1;
      t_dx  <= dseg[DIV_STAGES].dx;
      t_dy  <= dseg[DIV_STAGES].dy;
      m_sx  <= $signed({1'b0, t_u1}) * t_dx;
      m_sy  <= $signed({1'b0, t_u1}) * t_dy;
      m_ex  <= $signed({1'b0, t_u2}) * t_dx;
      m_ey  <= $signed({1'b0, t_u2}) * t_dy;
      m_vis   <= t_vis;
      m_start <= t_vis && (t_u1 != '0);
      m_end   <= t_vis && (t_u2 < U_ONE);
      m_x1  <= t_x1;
      m_y1  <= t_y1;
      m_dx  <= t_dx;
      m_dy  <= t_dy;
    end
  end

  // arithmetic shift floors toward minus infinity
  always_comb begin
    sx0 = OUT_BITS'(m_x1) <<< OUT_FRAC_BITS;
    sy0 = OUT_BITS'(m_y1) <<< OUT_FRAC_BITS;
    ex0 = (OUT_BITS'(m_x1) + OUT_BITS'(m_dx)) <<< OUT_FRAC_BITS;
    ey0 = (OUT_BITS'(m_y1) + OUT_BITS'(m_dy)) <<< OUT_FRAC_BITS;
    sxi = sx0 + OUT_BITS'(m_sx >>> SHIFT_BITS);
    syi = sy0 + OUT_BITS'(m_sy >>> SHIFT_BITS);
    exi = sx0 + OUT_BITS'(m_ex >>> SHIFT_BITS);
    eyi = sy0 + OUT_BITS'(m_ey >>> SHIFT_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      visible      <= m_vis;
      clip_start_x <= m_start ? sxi : sx0;
      clip_start_y <= m_start ? syi : sy0;
      clip_end_x   <= m_end ? exi : ex0;
      clip_end_y   <= m_end ? eyi : ey0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STAGES; s++) dv[s] <= 1'b0;
      tv        <= 1'b0;
      mv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      dv[0] <= q_pop;
      for (int s = 1; s <= DIV_STAGES; s++) dv[s] <= dv[s-1];
      tv        <= dv[DIV_STAGES];
      mv        <= tv;
      out_valid <= mv;
    end
  end

endmodule

// ===== rtl/line_segment_clipper_unit.sv =====
// ----------------------------------------------------------------------------
// line_segment_clipper_unit
// Liang-Barsky clipping of line segments against a configurable window.
// ----------------------------------------------------------------------------
// One segment is taken per cycle while the input queue is not full, and one
// result beat leaves per cycle while results are popped. The depth of the back
// pipeline is set by the four pipelined ratio dividers, which resolve three
// quotient bits per stage. The back pipeline halts as a whole while a result
// waits unpopped; the four-entry input queue takes up to four more segments
// before full rises.
module line_segment_clipper_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsc_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                push,
  output logic                                full,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] end_y,
  input  logic                                pop,
  output logic                                empty,
  output logic                                visible,
  output logic signed [lsc_pkg::OUT_BITS-1:0] clip_start_x,
  output logic signed [lsc_pkg::OUT_BITS-1:0] clip_start_y,
  output logic signed [lsc_pkg::OUT_BITS-1:0] clip_end_x,
  output logic signed [lsc_pkg::OUT_BITS-1:0] clip_end_y
);
  import lsc_pkg::*;

  logic signed [COORD_BITS-1:0] window_left, window_right;
  logic signed [COORD_BITS-1:0] window_bottom, window_top;
  logic [CFG_IDX_BITS-1:0]      cfg_idx;
  logic                         cfg_wr;
  seg_t                         f_seg, q_seg;
  qstat_t                       q_stat;
  logic                         q_push, q_pop;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left   <= -COORD_BITS'(150);
      window_right  <= COORD_BITS'(150);
      window_bottom <= -COORD_BITS'(150);
      window_top    <= COORD_BITS'(150);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_LEFT:   window_left   <= pwdata[COORD_BITS-1:0];
        CFG_RIGHT:  window_right  <= pwdata[COORD_BITS-1:0];
        CFG_BOTTOM: window_bottom <= pwdata[COORD_BITS-1:0];
        CFG_TOP:    window_top    <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_LEFT:   prdata = 32'(window_left);
      CFG_RIGHT:  prdata = 32'(window_right);
      CFG_BOTTOM: prdata = 32'(window_bottom);
      CFG_TOP:    prdata = 32'(window_top);
      default:    prdata = '0;
    endcase
  end

  assign full   = q_stat.full;
  assign q_push = push && !q_stat.full;

  lsc_front u_front (
    .window_left  (window_left),
    .window_right (window_right),
    .window_bottom(window_bottom),
    .window_top   (window_top),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .seg          (f_seg)
  );

  lsc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .wdata(f_seg),
    .rd   (q_pop),
    .rdata(q_seg),
    .stat (q_stat)
  );

  lsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .seg         (q_seg),
    .q_empty     (q_stat.empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .visible     (visible),
    .clip_start_x(clip_start_x),
    .clip_start_y(clip_start_y),
    .clip_end_x  (clip_end_x),
    .clip_end_y  (clip_end_y)
  );

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("back drew from an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result beat present right after reset");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks line_segment_clipper_unit against its own Liang-Barsky predictor. It
// runs directed segments, several clip windows, random segments, a long
// result hold-off and a gap-free stream, and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import lsc_pkg::*;

  typedef struct {
    bit          vis;
    logic [19:0] sx;
    logic [19:0] sy;
    logic [19:0] ex;
    logic [19:0] ey;
  } clip_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic signed [COORD_BITS-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic pop = 1'b0;
  logic empty;
  logic visible;
  logic signed [OUT_BITS-1:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;

  line_segment_clipper_unit dut (.*);

  clip_result_t pending_clips[$];
  longint window[4];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;

  localparam int unsigned CYCLE_LIMIT = 400000;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (hold_left > 0) hold_left--;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h (%0d pending)", what, got, want,
             pending_clips.size());
    err_count++;
  endtask

  // ratio q/p in u1.16, saturated just above one
  function automatic longint param_ratio(longint a, longint b);
    longint r;
    r = (a << PARAM_FRAC_BITS) / b;
    if (r > (1 << PARAM_FRAC_BITS) + 1) r = (1 << PARAM_FRAC_BITS) + 1;
    return r;
  endfunction

  function automatic bit edge_test(longint p, longint q, inout longint u1, inout longint u2);
    longint r;
    if (p > 0) begin
      if (q < 0) return 1'b0;
      r = param_ratio(q, p);
      if (r < u1) return 1'b0;
      if (r < u2) u2 = r;
    end else if (p < 0) begin
      if (q > 0) return 1'b1;
      r = param_ratio(-q, -p);
      if (r > u2) return 1'b0;
      if (r > u1) u1 = r;
    end else begin
      return q >= 0;
    end
    return 1'b1;
  endfunction

  // arithmetic shift gives the floor for negative products
  function automatic longint lerp_coord(longint x, longint u, longint d);
    return (x << OUT_FRAC_BITS) + ((u * d) >>> (PARAM_FRAC_BITS - OUT_FRAC_BITS));
  endfunction

  function automatic clip_result_t clip_segment(longint x1, longint y1, longint x2,
                                                longint y2);
    clip_result_t res;
    longint dx, dy, u1, u2, sx, sy, ex, ey;
    bit vis;
    dx = x2 - x1;
    dy = y2 - y1;
    u1 = 0;
    u2 = 1 << PARAM_FRAC_BITS;
    sx = x1 << OUT_FRAC_BITS;
    sy = y1 << OUT_FRAC_BITS;
    ex = x2 << OUT_FRAC_BITS;
    ey = y2 << OUT_FRAC_BITS;
    vis = edge_test(-dx, x1 - window[CFG_LEFT], u1, u2);
    if (vis) vis = edge_test(dx, window[CFG_RIGHT] - x1, u1, u2);
    if (vis) vis = edge_test(-dy, y1 - window[CFG_BOTTOM], u1, u2);
    if (vis) vis = edge_test(dy, window[CFG_TOP] - y1, u1, u2);
    if (vis) begin
      if (u2 < (1 << PARAM_FRAC_BITS)) begin
        ex = lerp_coord(x1, u2, dx);
        ey = lerp_coord(y1, u2, dy);
      end
      if (u1 > 0) begin
        sx = lerp_coord(x1, u1, dx);
        sy = lerp_coord(y1, u1, dy);
      end
    end
    res.vis = vis;
    res.sx = sx[19:0];
    res.sy = sy[19:0];
    res.ex = ex[19:0];
    res.ey = ey[19:0];
    return res;
  endfunction

  task automatic write_window(logic [CFG_IDX_BITS-1:0] idx, longint value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    window[idx] = longint'(signed'(value[15:0]));
  endtask

  task automatic set_window(longint l, longint r, longint b, longint t);
    write_window(CFG_LEFT, l);
    write_window(CFG_RIGHT, r);
    write_window(CFG_BOTTOM, b);
    write_window(CFG_TOP, t);
  endtask

  task automatic send_segment(longint x1, longint y1, longint x2, longint y2);
    bit was_full;
    push <= 1'b1;
    start_x <= x1[15:0];
    start_y <= y1[15:0];
    end_x <= x2[15:0];
    end_y <= y2[15:0];
    do begin
      @(negedge clk);
      was_full = full;
      @(posedge clk);
    end while (was_full);
    pending_clips.push_back(clip_segment(longint'(signed'(x1[15:0])),
                                         longint'(signed'(y1[15:0])),
                                         longint'(signed'(x2[15:0])),
                                         longint'(signed'(y2[15:0]))));
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // drain before touching the window; pipeline is 10 deep
  task automatic drain();
    push <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    clip_result_t want;
    bit was_empty, was_pop;
    int unsigned burst = 0;
    forever begin
      @(negedge clk);
      was_empty = empty;
      was_pop = pop;
      @(posedge clk);
      if (was_pop && !was_empty) begin
        if (pending_clips.size() == 0) begin
          report("unexpected beat", visible, 0);
        end else begin
          want = pending_clips.pop_front();
          if (visible !== want.vis) report("visible", visible, want.vis);
          if (clip_start_x !== want.sx) report("clip_start_x", clip_start_x, want.sx);
          if (clip_start_y !== want.sy) report("clip_start_y", clip_start_y, want.sy);
          if (clip_end_x !== want.ex) report("clip_end_x", clip_end_x, want.ex);
          if (clip_end_y !== want.ey) report("clip_end_y", clip_end_y, want.ey);
        end
      end
      if (rst || hold_left > 0) begin
        pop <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        pop <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic longint near_coord(longint lo, longint hi);
    longint v;
    if (lo > hi || $urandom_range(0, 4) == 0) return longint'(signed'(16'($urandom)));
    v = lo - 64 + longint'($urandom_range(0, int'(hi - lo) + 128));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic send_random(int n);
    repeat (n) begin
      send_segment(near_coord(window[CFG_LEFT], window[CFG_RIGHT]),
                   near_coord(window[CFG_BOTTOM], window[CFG_TOP]),
                   near_coord(window[CFG_LEFT], window[CFG_RIGHT]),
                   near_coord(window[CFG_BOTTOM], window[CFG_TOP]));
    end
  endtask

  task automatic test_default_window();
    set_window(-150, 150, -150, 150);
    send_segment(0, 0, 0, 0);
    send_segment(200, 0, 200, 0);
    send_segment(150, 150, 150, 150);
    send_segment(151, 150, 151, 150);
    send_segment(-200, 0, 200, 0);
    send_segment(0, -200, 0, 200);
    send_segment(-100, -100, 100, 100);
    send_segment(-200, -200, 200, 100);
    send_segment(200, 0, 300, 0);
    send_segment(300, 300, 400, 500);
    send_segment(32767, 32767, -32768, -32768);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(-32768, 0, 32767, 0);
    send_segment(0, 32767, 0, -32768);
    send_segment(160, -10, -10, 160);
    send_segment(100, 200, 200, 100);
    send_segment(-151, 0, -150, 0);
    send_segment(7, 3, -200, 11);
    send_segment(-3, 299, 5, -301);
    drain();
  endtask

  task automatic test_extreme_windows();
    set_window(-32768, 32767, -32768, 32767);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-1, 0, 1, -1);
    drain();
    set_window(0, 0, 0, 0);
    send_segment(0, 0, 0, 0);
    send_segment(-5, 0, 5, 0);
    send_segment(-5, -5, 5, 5);
    send_segment(1, 1, 1, 1);
    drain();
    set_window(100, -100, 50, -50);
    send_segment(0, 0, 0, 0);
    send_segment(-200, 0, 200, 0);
    send_segment(150, 60, -150, -60);
    drain();
  endtask

  task automatic test_random_windows();
    longint l, b;
    for (int k = 0; k < 5; k++) begin
      if (k == 0) begin
        set_window(-150, 150, -150, 150);
      end else begin
        l = longint'($urandom_range(0, 2000)) - 1000;
        b = longint'($urandom_range(0, 2000)) - 1000;
        set_window(l, l + $urandom_range(0, 800), b, b + $urandom_range(0, 800));
      end
      send_random(180);
      drain();
    end
  endtask

  task automatic test_result_hold();
    hold_left = 300;
    send_random(40);
    drain();
  endtask

  task automatic test_back_to_back();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random(120);
    drain();
  endtask

  initial begin
    window[CFG_LEFT] = -150;
    window[CFG_RIGHT] = 150;
    window[CFG_BOTTOM] = -150;
    window[CFG_TOP] = 150;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_window();
    test_extreme_windows();
    test_random_windows();
    test_result_hold();
    test_back_to_back();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
